[hdl/weighted_region_difference_macros.svh]
// Assertion helpers for the RTL.
`ifndef WEIGHTED_REGION_DIFFERENCE_MACROS_SVH
`define WEIGHTED_REGION_DIFFERENCE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WRD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define WRD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/wrd_pkg.sv]
`timescale 1ns / 1ps

package wrd_pkg;

  localparam int DST_WORDS = 65536;
  localparam int SRC_WORDS = 4096;
  localparam int FRAC_BITS = 16;

  localparam int DST_AW = $clog2(DST_WORDS);
  localparam int SRC_AW = $clog2(SRC_WORDS);

  localparam int MODE_W    = 2;
  localparam int ADDR_W    = 16;
  localparam int PIXEL_W   = 32;
  localparam int PIX_W     = 31;
  localparam int POSX_W    = 7;
  localparam int POSY_W    = 9;
  localparam int DIFF_W    = 16;

  localparam int DW_W      = 8;
  localparam int DH_W      = 10;
  localparam int SIDE_W    = 7;
  localparam int CNT_W     = 2 * SIDE_W;

  localparam int SQSUM_W   = 18;
  localparam int WGT_W     = 8;
  localparam int TERM_W    = 26;
  localparam int ACC_W     = 38;

  localparam int FULL_SCALE = 3 * 255 * 255 * 254;
  localparam int FS_W       = 26;
  localparam int DEN_W      = CNT_W + FS_W;
  localparam int DIV_W      = DEN_W + FRAC_BITS + 2;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int RESULT_SAT = (FRAC_BITS < DIFF_W) ? (1 << FRAC_BITS) - 1
                                                   : (1 << DIFF_W) - 1;

  localparam int STEPS_MAX = (QUO_W > POSY_W) ? QUO_W : POSY_W;
  localparam int STEP_W    = $clog2(STEPS_MAX + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [MODE_W-1:0] MODE_LOAD_DST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_SRC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPARE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_H     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_V     = 3'd5;

endpackage

[hdl/wrd_ram.sv]
`timescale 1ns / 1ps

module wrd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/weighted_region_difference.sv]
`timescale 1ns / 1ps
// Weighted region difference.
// Load items (mode 0 destination, mode 1 source) write one pixel each into
// the pixel memories and give no result; busy stays low.
// A compare item (mode 2) walks the source region placed at pos_x, pos_y,
// reading one source and one destination pixel per cycle from the two
// memories, and accumulates the alpha-weighted squared RGB difference.
// The mean is formed by a bit-serial divider.
// busy is high while a compare is in progress and drops as its result is
// given; no new item is accepted while it is high.
// An offset outside a non-wrapping destination gives status 1 in the
// cycle after the transfer. Each result shows for one cycle with done high;
// the receiver cannot stall, so nothing waits behind it.
// Configuration writes take effect at once and belong only in idle time.
// Reset restores the register defaults and clears control state; the
// pixel memories are not cleared and must be loaded before use.
`include "weighted_region_difference_macros.svh"

module weighted_region_difference (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [wrd_pkg::MODE_W-1:0]        mode,
  input  logic [wrd_pkg::ADDR_W-1:0]        addr,
  input  logic [wrd_pkg::PIXEL_W-1:0]       pixel,
  input  logic [wrd_pkg::POSX_W-1:0]        pos_x,
  input  logic [wrd_pkg::POSY_W-1:0]        pos_y,
  input  logic                              cfg_write,
  input  logic [wrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wrd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              done,
  output logic [wrd_pkg::DIFF_W-1:0]        difference,
  output logic                              status
);

  import wrd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_BASE,
    ST_WALK,
    ST_DRAIN,
    ST_DIV
  } state_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  state_t state;

  // configuration registers
  logic [DW_W-1:0]   dst_width;
  logic [DH_W-1:0]   dst_height;
  logic [SIDE_W-1:0] src_width;
  logic [SIDE_W-1:0] src_height;
  logic              wrap_horizontal;
  logic              wrap_vertical;

  logic [DW_W-1:0]   dw_eff;
  logic [DH_W-1:0]   dh_eff;
  logic [SIDE_W-1:0] sw_eff;
  logic [SIDE_W-1:0] sh_eff;

  // compare setup
  logic [SIDE_W-1:0] cw;
  logic [SIDE_W-1:0] ch;
  logic [POSY_W-1:0] mx;
  logic [POSY_W-1:0] my;
  logic [DW_W-1:0]   rem_x;
  logic [DH_W-1:0]   rem_y;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  n_pix;
  logic [DEN_W-1:0]  den;

  // region walk
  logic [SIDE_W-1:0] x_cnt;
  logic [SIDE_W-1:0] y_cnt;
  logic [SRC_AW-1:0] sa;
  logic [SRC_AW-1:0] sa_row;
  logic [DW_W-1:0]   dx;
  logic [DW_W-1:0]   dx0;
  logic [DH_W-1:0]   dy;
  logic [DST_AW-1:0] dbase;

  // datapath pipeline
  logic               v0, v1, v2;
  logic [SQSUM_W-1:0] sqsum1;
  logic [WGT_W-1:0]   wgt1;
  logic [TERM_W-1:0]  term2;
  logic [ACC_W-1:0]   acc;

  // divider
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [QUO_W-1:0] quo;

  // memories
  logic              dst_we, src_we;
  logic [DST_AW-1:0] dst_raddr;
  logic [PIX_W-1:0]  dst_rdata, src_rdata;

  logic accept;
  logic err;
  logic clip_x, clip_y;
  logic [SIDE_W-1:0] cw_in, ch_in;

  logic [DW_W:0]     tx;
  logic [DH_W:0]     ty;
  logic [DW_W-1:0]   rx_next;
  logic [DH_W-1:0]   ry_next;
  logic [17:0]       base_full;

  logic              last_x, last_y;
  logic [7:0]        ad_r, ad_g, ad_b;
  logic [15:0]       sq_r, sq_g, sq_b;
  logic [8:0]        wgt_full;
  logic [ACC_W:0]    acc_sum;

  logic              div_ge;
  logic [DIV_W-1:0]  rem_next;
  logic [QUO_W-1:0]  quo_next;
  logic [DIFF_W-1:0] diff_sat;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign dw_eff = (dst_width  == '0) ? DW_W'(1)   : dst_width;
  assign dh_eff = (dst_height == '0) ? DH_W'(1)   : dst_height;
  assign sw_eff = (src_width  == '0) ? SIDE_W'(1) : src_width;
  assign sh_eff = (src_height == '0) ? SIDE_W'(1) : src_height;

  assign err = (!wrap_horizontal && (DW_W'(pos_x) >= dw_eff)) ||
               (!wrap_vertical && (DH_W'(pos_y) >= dh_eff));
  assign clip_x = !wrap_horizontal &&
                  ((9'(pos_x) + 9'(sw_eff)) >= 9'(dw_eff));
  assign clip_y = !wrap_vertical &&
                  ((11'(pos_y) + 11'(sh_eff)) >= 11'(dh_eff));
  assign cw_in = clip_x ? SIDE_W'(dw_eff - DW_W'(pos_x)) : sw_eff;
  assign ch_in = clip_y ? SIDE_W'(dh_eff - DH_W'(pos_y)) : sh_eff;

  // restoring remainder, one bit of the offset per step
  assign tx      = {rem_x, mx[POSY_W-1]};
  assign ty      = {rem_y, my[POSY_W-1]};
  assign rx_next = (tx >= (DW_W+1)'(dw_eff)) ? DW_W'(tx - (DW_W+1)'(dw_eff)) : DW_W'(tx);
  assign ry_next = (ty >= (DH_W+1)'(dh_eff)) ? DH_W'(ty - (DH_W+1)'(dh_eff)) : DH_W'(ty);

  assign base_full = 18'(rem_y) * 18'(dw_eff);

  assign last_x = (x_cnt + SIDE_W'(1) == cw);
  assign last_y = (y_cnt + SIDE_W'(1) == ch);

  assign dst_we = accept && (mode == MODE_LOAD_DST) && (32'(addr) < DST_WORDS);
  assign src_we = accept && (mode == MODE_LOAD_SRC) && (32'(addr) < SRC_WORDS);
  assign dst_raddr = dbase + DST_AW'(dx);

  assign ad_r = abs_diff(src_rdata[23:16], dst_rdata[23:16]);
  assign ad_g = abs_diff(src_rdata[15:8],  dst_rdata[15:8]);
  assign ad_b = abs_diff(src_rdata[7:0],   dst_rdata[7:0]);
  assign sq_r = 16'(ad_r) * 16'(ad_r);
  assign sq_g = 16'(ad_g) * 16'(ad_g);
  assign sq_b = 16'(ad_b) * 16'(ad_b);
  // both alphas are at most 127, so the weight never goes negative
  assign wgt_full = 9'd254 - 9'(src_rdata[30:24]) - 9'(dst_rdata[30:24]);

  assign acc_sum = (ACC_W+1)'(acc) + (ACC_W+1)'(term2);

  assign div_ge   = (rem >= dvs);
  assign rem_next = div_ge ? rem - dvs : rem;
  assign quo_next = {quo[QUO_W-2:0], div_ge};
  assign diff_sat = (quo_next > QUO_W'(RESULT_SAT)) ? DIFF_W'(RESULT_SAT)
                                                    : DIFF_W'(quo_next);

  wrd_ram #(.WIDTH(PIX_W), .DEPTH(DST_WORDS)) u_dst_ram (
    .clk   (clk),
    .we    (dst_we),
    .waddr (DST_AW'(addr)),
    .wdata (pixel[PIX_W-1:0]),
    .raddr (dst_raddr),
    .rdata (dst_rdata)
  );

  wrd_ram #(.WIDTH(PIX_W), .DEPTH(SRC_WORDS)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (SRC_AW'(addr)),
    .wdata (pixel[PIX_W-1:0]),
    .raddr (sa),
    .rdata (src_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      done            <= 1'b0;
      v0              <= 1'b0;
      v1              <= 1'b0;
      v2              <= 1'b0;
      acc             <= '0;
      dst_width       <= DW_W'(128);
      dst_height      <= DH_W'(512);
      src_width       <= SIDE_W'(64);
      src_height      <= SIDE_W'(64);
      wrap_horizontal <= 1'b0;
      wrap_vertical   <= 1'b1;
    end else begin
      done <= 1'b0;
      v0   <= (state == ST_WALK);
      v1   <= v0;
      v2   <= v1;
      if (v2) begin
        acc <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
      end

      if (cfg_write) begin
        unique case (cfg_index)
          REG_DST_WIDTH:  dst_width       <= cfg_data[DW_W-1:0];
          REG_DST_HEIGHT: dst_height      <= cfg_data[DH_W-1:0];
          REG_SRC_WIDTH:  src_width       <= cfg_data[SIDE_W-1:0];
          REG_SRC_HEIGHT: src_height      <= cfg_data[SIDE_W-1:0];
          REG_WRAP_H:     wrap_horizontal <= cfg_data[0];
          REG_WRAP_V:     wrap_vertical   <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (accept && (mode == MODE_COMPARE)) begin
            if (err) begin
              done       <= 1'b1;
              difference <= '0;
              status     <= 1'b1;
            end else begin
              acc    <= '0;
              cw     <= cw_in;
              ch     <= ch_in;
              mx     <= POSY_W'(pos_x);
              my     <= pos_y;
              rem_x  <= '0;
              rem_y  <= '0;
              step   <= '0;
              x_cnt  <= '0;
              y_cnt  <= '0;
              sa     <= '0;
              sa_row <= '0;
              state  <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          rem_x <= rx_next;
          rem_y <= ry_next;
          mx    <= mx << 1;
          my    <= my << 1;
          step  <= step + STEP_W'(1);
          if (step == STEP_W'(POSY_W - 1)) begin
            state <= ST_BASE;
          end
        end
        ST_BASE: begin
          dx    <= rem_x;
          dx0   <= rem_x;
          dy    <= rem_y;
          dbase <= DST_AW'(base_full);
          n_pix <= CNT_W'(cw) * CNT_W'(ch);
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (last_x) begin
            x_cnt  <= '0;
            y_cnt  <= y_cnt + SIDE_W'(1);
            sa     <= sa_row + SRC_AW'(sw_eff);
            sa_row <= sa_row + SRC_AW'(sw_eff);
            dx     <= dx0;
            if (dy + DH_W'(1) == dh_eff) begin
              dy    <= '0;
              dbase <= '0;
            end else begin
              dy    <= dy + DH_W'(1);
              dbase <= dbase + DST_AW'(dw_eff);
            end
            if (last_y) begin
              state <= ST_DRAIN;
            end
          end else begin
            x_cnt <= x_cnt + SIDE_W'(1);
            sa    <= sa + SRC_AW'(1);
            dx    <= (dx + DW_W'(1) == dw_eff) ? '0 : dx + DW_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!v0 && !v1 && !v2) begin
            // rounded mean: (acc * 2^(F+1) + den) / (2 * den)
            rem   <= DIV_W'({acc, {(FRAC_BITS + 1){1'b0}}}) + DIV_W'(den);
            dvs   <= DIV_W'({den, 1'b0}) << FRAC_BITS;
            quo   <= '0;
            step  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          dvs  <= dvs >> 1;
          quo  <= quo_next;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(FRAC_BITS)) begin
            done       <= 1'b1;
            difference <= diff_sat;
            status     <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sqsum1 <= SQSUM_W'(sq_r) + SQSUM_W'(sq_g) + SQSUM_W'(sq_b);
    wgt1   <= wgt_full[WGT_W-1:0];
    term2  <= TERM_W'(sqsum1) * TERM_W'(wgt1);
    den    <= DEN_W'(n_pix) * DEN_W'(FULL_SCALE);
  end

  `WRD_ASSERT_IMPL(a_idle_pipe_empty, state == ST_IDLE, !(v0 || v1 || v2), "pipeline busy while idle")
  `WRD_ASSERT_IMPL(a_walk_in_region, state == ST_WALK, (x_cnt < cw) && (y_cnt < ch), "walk outside region")
  `WRD_ASSERT_IMPL(a_walk_dst_coord, state == ST_WALK, (dx < dw_eff) && (dy < dh_eff), "destination coordinate not reduced")
  `WRD_ASSERT_IMPL(a_err_zero, done && status, difference == '0, "error result with nonzero difference")
  `WRD_ASSERT_NEXT(a_acc_monotonic, state == ST_DRAIN, acc >= $past(acc), "accumulator decreased during drain")

endmodule
